// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/yuvx_pkg.sv =====
// ----------------------------------------------------------------------------
// yuvx_pkg
// Types, format codes and BT.601 term tables for the YCbCr to xRGB converter.
// ----------------------------------------------------------------------------
package yuvx_pkg;

  // Output format codes; code 3 is unused and converts like RGB.
  typedef enum logic [1:0] {
    FMT_GREY = 2'd0,
    FMT_RAW  = 2'd1,
    FMT_RGB  = 2'd2
  } fmt_t;

  // Fixed point: each coefficient is (coef * 8192 + 0.5), scaled by 1000.
  localparam longint Y_COEF    = 64'sd9535988;
  localparam longint RV_COEF   = 64'sd13074932;
  localparam longint GU_COEF   = 64'sd3203572;
  localparam longint GV_COEF   = 64'sd6660596;
  localparam longint BU_COEF   = 64'sd16531956;
  localparam longint COEF_DEN  = 64'sd1000;
  localparam int     FRAC_BITS = 13;
  localparam longint Y_OFFSET  = 64'sd16;
  localparam longint C_OFFSET  = 64'sd128;

  // A single term fits in 23 signed bits and a channel sum in 24; both types leave headroom.
  localparam int TERM_W = 24;
  localparam int SUM_W  = 26;

  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef term_t term_tab_t [256];

  // Builds trunc(Coef * (s - Offset) / 1000) for every 8-bit sample s.
  // Evaluated at elaboration only; the division truncates toward zero.
  function automatic term_tab_t build_term_tab(longint Coef, longint Offset);
    term_tab_t tab;
    longint    prod;
    for (int s = 0; s < 256; s++) begin
      prod   = Coef * (longint'(s) - Offset);
      tab[s] = TERM_W'(prod / COEF_DEN);
    end
    return tab;
  endfunction

  localparam term_tab_t Y_TAB  = build_term_tab(Y_COEF, Y_OFFSET);
  localparam term_tab_t RV_TAB = build_term_tab(RV_COEF, C_OFFSET);
  localparam term_tab_t GU_TAB = build_term_tab(GU_COEF, C_OFFSET);
  localparam term_tab_t GV_TAB = build_term_tab(GV_COEF, C_OFFSET);
  localparam term_tab_t BU_TAB = build_term_tab(BU_COEF, C_OFFSET);

endpackage

// ===== sv/yuv420_to_xrgb_pixel.sv =====
// ----------------------------------------------------------------------------
// yuv420_to_xrgb_pixel
// Converts a 4:2:0 YCbCr pixel stream to packed 24-bit pixels (grey, raw
// YCbCr or BT.601 RGB), reusing the chroma pair across each column pair.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid / in_ready   | luma, chroma_blue/red, row_start
//  out     | output    | out_valid / out_ready | byte_high, byte_mid, byte_low
//  cfg     | input     | cfg_valid / cfg_ready | output format (2 bits)
//
//  One pixel per clock while the output is not stalled. The term table
//  lookup, the add of up to three terms and the clamp stage sit between the
//  input and result registers.
//  Reset (rst_n low, synchronous) empties both stages, clears the column
//  pairing, sets the held chroma to 0x80 and selects RGB output.
//  A stalled result holds the output register; the input stage keeps taking
//  requests until it is full as well.
//
module yuv420_to_xrgb_pixel (
  input  logic       clk,
  input  logic       rst_n,
  // Pixel requests.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_luma,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_chroma_red,
  input  logic       in_row_start,
  // Converted pixels.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_high,
  output logic [7:0] out_byte_mid,
  output logic [7:0] out_byte_low,
  // Format register writes.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);
  import yuvx_pkg::*;

  fmt_t       fmt_r;
  logic       odd_col_r, odd_col_nxt;
  logic       s1_valid_r;
  logic [7:0] s1_luma_r;
  logic [7:0] held_cb_r, held_cb_nxt;
  logic [7:0] held_cr_r, held_cr_nxt;
  logic       in_acc, s1_adv, latch;
  term_t      ty, trv, tgu, tgv, tbu;
  sum_t       sum_r, sum_g, sum_b;
  logic [7:0] byte_high_nxt, byte_mid_nxt, byte_low_nxt;
  logic       out_valid_r;
  logic [7:0] out_high_r, out_mid_r, out_low_r;

  // Format register: always writable; the port is to be used only while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGB;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= fmt_t'(cfg_data);
    end
  end

  // Pipeline flow: the result register advances when empty or taken.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Chroma is latched on the even column of a row and reused on the odd one.
  always_comb begin
    latch       = in_row_start || !odd_col_r;
    odd_col_nxt = latch;
    held_cb_nxt = latch ? in_chroma_blue : held_cb_r;
    held_cr_nxt = latch ? in_chroma_red  : held_cr_r;
  end

  // Input stage; the held chroma doubles as this stage's chroma payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      odd_col_r  <= 1'b0;
      held_cb_r  <= 8'h80;
      held_cr_r  <= 8'h80;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        odd_col_r  <= odd_col_nxt;
        held_cb_r  <= held_cb_nxt;
        held_cr_r  <= held_cr_nxt;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_luma_r <= in_luma;
    end
  end

  // Term lookups and channel sums.
  always_comb begin
    ty    = Y_TAB[s1_luma_r];
    trv   = RV_TAB[held_cr_r];
    tgu   = GU_TAB[held_cb_r];
    tgv   = GV_TAB[held_cr_r];
    tbu   = BU_TAB[held_cb_r];
    sum_r = SUM_W'(ty) + SUM_W'(trv);
    sum_g = SUM_W'(ty) - (SUM_W'(tgu) + SUM_W'(tgv));
    sum_b = SUM_W'(ty) + SUM_W'(tbu);
  end

  // Floor by 2^13 and clamp to 0..255.
  function automatic logic [7:0] clamp_byte(sum_t s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = 8'd0;
    end else if (|s[SUM_W-2:FRAC_BITS+8]) begin
      res = 8'hFF;
    end else begin
      res = s[FRAC_BITS+7:FRAC_BITS];
    end
    return res;
  endfunction

  // Output byte selection per format.
  always_comb begin
    unique case (fmt_r)
      FMT_GREY: begin
        byte_high_nxt = s1_luma_r;
        byte_mid_nxt  = s1_luma_r;
        byte_low_nxt  = s1_luma_r;
      end
      FMT_RAW: begin
        byte_high_nxt = s1_luma_r;
        byte_mid_nxt  = held_cb_r;
        byte_low_nxt  = held_cr_r;
      end
      default: begin
        byte_high_nxt = clamp_byte(sum_r);
        byte_mid_nxt  = clamp_byte(sum_g);
        byte_low_nxt  = clamp_byte(sum_b);
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_high_r <= byte_high_nxt;
      out_mid_r  <= byte_mid_nxt;
      out_low_r  <= byte_low_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte_high = out_high_r;
  assign out_byte_mid  = out_mid_r;
  assign out_byte_low  = out_low_r;

endmodule

// ===== sv/yuvx_checker.sv =====
// ----------------------------------------------------------------------------
// yuvx_checker
// Port-level checks for the YCbCr to xRGB converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yuvx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_high,
  input logic [7:0] out_byte_mid,
  input logic [7:0] out_byte_low
);

  // Reset leaves no result pending.
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result stays offered and unchanged.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte_high) && $stable(out_byte_mid) && $stable(out_byte_low), "stalled result changed")

  // An accepted request must be followed by a result once through the input and result registers.
  `ASSERT_CLK(a_latency, clk, rst_n, in_valid && in_ready |=> ##1 out_valid, "result missing after request")

  // Input back-pressure only comes from a stalled, full pipeline.
  `ASSERT_CLK(a_ready_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")

endmodule

bind yuv420_to_xrgb_pixel yuvx_checker u_yuvx_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte_high (out_byte_high),
  .out_byte_mid  (out_byte_mid),
  .out_byte_low  (out_byte_low)
);

// ===== verif/yuv420_to_xrgb_pixel_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuv420_to_xrgb_pixel_test
// Self-checking bench for the YCbCr 4:2:0 to packed 24-bit pixel converter.
// A short list of hand-picked requests covers the sample extremes, every
// output format, chroma reuse across column pairs and row restarts. Random
// rows of pixels follow under every format setting. Each accepted request is
// run through a fixed-point BT.601 pixel model; pixels are compared in order
// with its results (listed values for typed rows). Both sides idle at random.
// ----------------------------------------------------------------------------
module yuv420_to_xrgb_pixel_test;
  import yuvx_pkg::*;

  // Spare format code; the block converts it like RGB.
  localparam logic [1:0] FMT_SPARE = 2'd3;

  // BT.601 gains: (coef * 8192 + 0.5) scaled by GAIN_DIV, 13 fraction bits.
  localparam longint LUMA_GAIN   = 64'sd9535988;
  localparam longint CR_TO_RED   = 64'sd13074932;
  localparam longint CB_TO_GREEN = 64'sd3203572;
  localparam longint CR_TO_GREEN = 64'sd6660596;
  localparam longint CB_TO_BLUE  = 64'sd16531956;
  localparam longint GAIN_DIV    = 64'sd1000;
  localparam int     SCALE_SHIFT = 13;

  localparam int PHASES         = 8;
  localparam int PIXELS_PER_PHASE = 132;
  localparam int DIRECTED_COUNT = 22;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] mid;
    logic [7:0] lo;
  } pixel_t;

  // One hand-picked request; typed marks rows whose result is written out here.
  typedef struct {
    logic [1:0] fmt;
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       row_start;
    bit         typed;
    pixel_t     want;
  } pixel_req_t;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_luma        = 8'd0;
  logic [7:0] in_chroma_blue = 8'd0;
  logic [7:0] in_chroma_red  = 8'd0;
  logic       in_row_start   = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] out_byte_high;
  logic [7:0] out_byte_mid;
  logic [7:0] out_byte_low;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data       = 2'd0;

  // Pixel model state.
  logic [1:0] cur_format = FMT_RGB;
  bit         odd_col    = 1'b0;
  logic [7:0] held_cb    = 8'h80;
  logic [7:0] held_cr    = 8'h80;

  pixel_t expected_pixels [$];
  int     mismatches = 0;
  bit     send_idle  = 1'b1;
  bit     recv_idle  = 1'b1;
  int     stall_left = 0;
  pixel_t want_px;
  pixel_t got_px;

  // Hand-picked requests: extremes, chroma reuse, row restarts, every format.
  pixel_req_t directed_reqs [DIRECTED_COUNT] = '{
    '{FMT_RGB,   8'd16,  8'd128, 8'd128, 1'b1, 1'b1, 24'h000000},
    '{FMT_RGB,   8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 24'hFFFFFF},
    '{FMT_RGB,   8'd0,   8'd128, 8'd128, 1'b1, 1'b1, 24'h000000},
    '{FMT_RGB,   8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 24'hFFFFFF},
    '{FMT_RGB,   8'd128, 8'd0,   8'd255, 1'b1, 1'b0, 24'h000000},
    '{FMT_RGB,   8'd128, 8'd255, 8'd0,   1'b0, 1'b0, 24'h000000},
    '{FMT_RGB,   8'd235, 8'd255, 8'd255, 1'b0, 1'b0, 24'h000000},
    '{FMT_RGB,   8'd16,  8'd0,   8'd0,   1'b1, 1'b0, 24'h000000},
    '{FMT_RGB,   8'd81,  8'd90,  8'd240, 1'b1, 1'b0, 24'h000000},
    '{FMT_GREY,  8'd0,   8'd255, 8'd0,   1'b1, 1'b1, 24'h000000},
    '{FMT_GREY,  8'd255, 8'd0,   8'd255, 1'b0, 1'b1, 24'hFFFFFF},
    '{FMT_GREY,  8'h5A,  8'hAA,  8'h55,  1'b0, 1'b1, 24'h5A5A5A},
    '{FMT_RAW,   8'h12,  8'h34,  8'h56,  1'b0, 1'b1, 24'h12AA55},
    '{FMT_RAW,   8'hFF,  8'h00,  8'h00,  1'b0, 1'b1, 24'hFF0000},
    '{FMT_RAW,   8'h00,  8'hFF,  8'h80,  1'b0, 1'b1, 24'h000000},
    '{FMT_RAW,   8'h80,  8'h7F,  8'h01,  1'b1, 1'b1, 24'h807F01},
    '{FMT_RAW,   8'h01,  8'hFF,  8'hFF,  1'b1, 1'b1, 24'h01FFFF},
    '{FMT_SPARE, 8'd16,  8'd128, 8'd128, 1'b1, 1'b1, 24'h000000},
    '{FMT_SPARE, 8'd200, 8'd60,  8'd200, 1'b0, 1'b0, 24'h000000},
    '{FMT_SPARE, 8'd100, 8'd200, 8'd60,  1'b0, 1'b0, 24'h000000},
    '{FMT_RGB,   8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 24'h000000},
    '{FMT_RGB,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 24'h000000}
  };

  yuv420_to_xrgb_pixel u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .in_row_start   (in_row_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_high  (out_byte_high),
    .out_byte_mid   (out_byte_mid),
    .out_byte_low   (out_byte_low),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One product term, truncated toward zero like the hardware tables.
  function automatic longint scale_term(input longint gain, input longint diff);
    return (gain * diff) / GAIN_DIV;
  endfunction

  // Floor by 2^13 and saturate to one byte.
  function automatic logic [7:0] clamp_channel(input longint sum);
    longint q;
    q = sum >>> SCALE_SHIFT;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // Converts one pixel, updating the column pairing and held chroma.
  function automatic pixel_t convert_pixel(input logic [7:0] y, input logic [7:0] cb,
                                           input logic [7:0] cr, input logic rs);
    pixel_t px;
    bit     latch;
    longint du;
    longint dv;
    longint ty;
    latch = rs || !odd_col;
    if (latch) begin
      held_cb = cb;
      held_cr = cr;
    end
    odd_col = latch;
    case (cur_format)
      FMT_GREY: px = {y, y, y};
      FMT_RAW:  px = {y, held_cb, held_cr};
      default: begin
        du = longint'(held_cb) - 128;
        dv = longint'(held_cr) - 128;
        ty = scale_term(LUMA_GAIN, longint'(y) - 16);
        px.hi  = clamp_channel(ty + scale_term(CR_TO_RED, dv));
        px.mid = clamp_channel(ty - scale_term(CB_TO_GREEN, du)
                               - scale_term(CR_TO_GREEN, dv));
        px.lo  = clamp_channel(ty + scale_term(CB_TO_BLUE, du));
      end
    endcase
    return px;
  endfunction

  function automatic logic [7:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void report_pixel_error(input string what, input pixel_t want,
                                             input pixel_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected %h/%h/%h, got %h/%h/%h", $realtime, what,
               want.hi, want.mid, want.lo, got.hi, got.mid, got.lo);
    end
  endfunction

  // Presents one request after a random gap and records its expected pixel.
  task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                            input logic rs, input bit typed, input pixel_t want);
    int     gap;
    pixel_t pred;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_luma        <= y;
    in_chroma_blue <= cb;
    in_chroma_red  <= cr;
    in_row_start   <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = convert_pixel(y, cb, cr, rs);
    expected_pixels.push_back(typed ? want : pred);
  endtask

  // Writes the format register once the pipeline has drained.
  task automatic set_format(input logic [1:0] fmt);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= fmt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    cur_format = fmt;
  endtask

  // Request source: directed list first, then random rows per format phase.
  initial begin
    logic [1:0] phase_fmt;
    logic       rs;
    int         row_left;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_reqs[i]) begin
      if (directed_reqs[i].fmt != cur_format) set_format(directed_reqs[i].fmt);
      send_pixel(directed_reqs[i].luma, directed_reqs[i].cb, directed_reqs[i].cr,
                 directed_reqs[i].row_start, directed_reqs[i].typed, directed_reqs[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_fmt = FMT_GREY;
        1:       phase_fmt = FMT_RAW;
        2:       phase_fmt = FMT_SPARE;
        3:       phase_fmt = FMT_RGB;
        default: phase_fmt = 2'($urandom_range(0, 3));
      endcase
      set_format(phase_fmt);
      row_left = 0;
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        // Mostly well-formed rows; a stray row start now and then.
        if (row_left == 0) begin
          rs       = 1'b1;
          row_left = $urandom_range(1, 16);
        end else begin
          rs = ($urandom_range(0, 19) == 0);
        end
        row_left--;
        if ($urandom_range(0, 31) == 0) send_idle = !send_idle;
        send_pixel(draw_sample(), draw_sample(), draw_sample(), rs, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result sink: random stalls per pixel, in-order compare against expectations.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_px = {out_byte_high, out_byte_mid, out_byte_low};
        if (expected_pixels.size() == 0) begin
          report_pixel_error("unexpected pixel", '0, got_px);
        end else begin
          want_px = expected_pixels.pop_front();
          if (got_px.hi !== want_px.hi || got_px.mid !== want_px.mid ||
              got_px.lo !== want_px.lo) begin
            report_pixel_error("pixel mismatch", want_px, got_px);
          end
        end
        if ($urandom_range(0, 31) == 0) recv_idle = !recv_idle;
        stall_left = recv_idle ? $urandom_range(0, 3) : 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
